// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the particle ring design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/prur_pkg.sv -----
// ----------------------------------------------------------------------------
// prur_pkg
// Types and constants shared by the particle ring update and render block.
// ----------------------------------------------------------------------------
package prur_pkg;

   localparam int SLOTS_DEF   = 64;
   localparam int COORD_W     = 32;
   localparam int PAINT_W     = 32;
   localparam int LIFE_W      = 16;
   localparam int DIM_W       = 13;
   localparam int SCR_W       = 12;
   localparam int FRAC_W      = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   localparam logic CMD_SPAWN = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [DIM_W-1:0] DIM_MIN          = 13'd2;
   localparam logic [DIM_W-1:0] DIM_MAX          = 13'd4096;
   localparam logic [DIM_W-1:0] WIDTH_RESET      = 13'd320;
   localparam logic [DIM_W-1:0] HEIGHT_RESET     = 13'd200;

   typedef struct packed {
      logic                      cmd;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] vel_x;
      logic signed [COORD_W-1:0] vel_y;
      logic signed [COORD_W-1:0] vel_z;
      logic [PAINT_W-1:0]        paint;
      logic [LIFE_W-1:0]         lifespan;
   } req_type;

   typedef struct packed {
      logic               draw;
      logic [SCR_W-1:0]   block_x;
      logic [SCR_W-1:0]   block_y;
      logic [PAINT_W-1:0] block_paint;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic             on_screen;
      logic [SCR_W-1:0] coord;
   } proj_out_type;

endpackage

// ----- rtl/core/prur_req_if.sv -----
// ----------------------------------------------------------------------------
// prur_req_if
// Request channel: valid, ready and one spawn or tick request.
// ----------------------------------------------------------------------------
interface prur_req_if;
   import prur_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/core/prur_rsp_if.sv -----
// ----------------------------------------------------------------------------
// prur_rsp_if
// Result channel: valid, ready and one block to draw or an empty marker.
// ----------------------------------------------------------------------------
interface prur_rsp_if;
   import prur_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/core/prur_proj.sv -----
// ----------------------------------------------------------------------------
// prur_proj
// Two-stage screen projection of one Q16.16 coordinate: coord*40 + dim/2,
// truncated toward zero, and a check against the visible block range.
// ----------------------------------------------------------------------------
module prur_proj (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic signed [prur_pkg::COORD_W-1:0]   coord,
   input  logic [prur_pkg::DIM_W-1:0]            dim,
   output prur_pkg::proj_out_type                result
);
   import prur_pkg::*;

   localparam int T_W = COORD_W + 7;
   localparam int Q_W = T_W - FRAC_W;

   logic [T_W-1:0]     c_ext;
   logic [T_W-1:0]     t_in;
   logic [T_W-1:0]     t_ff;
   logic [DIM_W-2:0]   half;
   logic [Q_W-1:0]     q;
   logic [Q_W-1:0]     lim;
   logic               round_up;

   // Scaling by 40 is two shifted copies; the centering offset is in whole pixels.
   always_comb begin
      c_ext = T_W'(coord);
      half  = dim[DIM_W-1:1];
      t_in  = (c_ext << 5) + (c_ext << 3) + T_W'({half, {FRAC_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff <= t_in;
      end
   end

   // The arithmetic shift floors; a negative value with a fraction moves up by one.
   always_comb begin
      round_up         = t_ff[T_W-1] && (|t_ff[FRAC_W-1:0]);
      q                = t_ff[T_W-1:FRAC_W] + Q_W'(round_up);
      lim              = Q_W'(dim) - Q_W'(1);
      result.on_screen = !q[Q_W-1] && (q < lim);
      result.coord     = q[SCR_W-1:0];
   end

endmodule

// ----- rtl/core/particle_ring_update_render.sv -----
// ----------------------------------------------------------------------------
// particle_ring_update_render
// Ring of particle slots: spawn requests fill slots in ring order, tick
// requests age every live particle, move the survivors and emit each one's on-screen 2x2 block.
// ----------------------------------------------------------------------------
//   channel   direction   carries
//   req_ch    in          spawn or tick request
//   rsp_ch    out         block to draw or empty marker, last on final one
//   csr_*     in          screen width (index 0), screen height (index 1)
//
// A spawn leaves req_ch.ready high. A tick holds req_ch.ready low while the
// slot memory is walked one slot per cycle, and longer whenever rsp_ch
// stalls; the single read port of the slot memory sets this walk rate.
// A stalled result freezes the whole walk. Reset is synchronous, clears the
// live flags and ring pointer and restores the default screen size; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module particle_ring_update_render #(
   parameter int SLOTS = prur_pkg::SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   prur_req_if.sink                            req_ch,
   prur_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [prur_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prur_pkg::DIM_W-1:0]          csr_wdata
);
   import prur_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] END_CNT   = CNT_W'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] vel_x;
      logic signed [COORD_W-1:0] vel_y;
      logic signed [COORD_W-1:0] vel_z;
      logic [PAINT_W-1:0]        paint;
      logic [LIFE_W-1:0]         ticks;
   } slot_type;

   typedef struct packed {
      logic [SCR_W-1:0]   x;
      logic [SCR_W-1:0]   y;
      logic [PAINT_W-1:0] paint;
   } blk_type;

   // Configuration and control.
   logic [DIM_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic [DIM_W-1:0]  width_cl, height_cl;
   logic              busy_ff, busy_in, issue_ff, issue_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  wslot_ff, wslot_in;
   logic [SLOTS-1:0]  alive_ff, alive_in;

   // Slot memory and walk pipeline.
   slot_type          slot_mem [SLOTS];
   slot_type          rd_data_ff;
   logic              u_valid_ff, u_valid_in, u_fin_ff, u_fin_in;
   logic [IDX_W-1:0]  u_idx_ff, u_idx_in;
   logic              t_valid_ff, t_valid_in, t_fin_ff, t_fin_in, t_keep_ff, t_keep_in;
   logic [PAINT_W-1:0] t_paint_ff, t_paint_in;
   logic              hold_valid_ff, hold_valid_in;
   blk_type           hold_ff, hold_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              adv, req_acc, spawn_acc, tick_acc, rd_en;
   logic              u_live, u_keep, q_draw, push;
   slot_type          u_next, mem_wdata;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   proj_out_type      proj_x, proj_y;

   always_comb begin
      width_cl  = (width_ff < DIM_MIN) ? DIM_MIN :
                  ((width_ff > DIM_MAX) ? DIM_MAX : width_ff);
      height_cl = (height_ff < DIM_MIN) ? DIM_MIN :
                  ((height_ff > DIM_MAX) ? DIM_MAX : height_ff);
   end

   // The whole walk advances only when the output register can take a push.
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !busy_ff;
   assign req_acc      = req_ch.valid && !busy_ff;
   assign spawn_acc    = req_acc && (req_ch.data.cmd == CMD_SPAWN);
   assign tick_acc     = req_acc && (req_ch.data.cmd == CMD_TICK);
   assign rd_en        = adv && issue_ff && (cnt_ff != END_CNT);

   always_comb begin
      u_live       = u_valid_ff && !u_fin_ff && alive_ff[u_idx_ff];
      u_keep       = u_live && (rd_data_ff.ticks > LIFE_W'(1));
      u_next       = rd_data_ff;
      u_next.pos_x = rd_data_ff.pos_x + rd_data_ff.vel_x;
      u_next.pos_y = rd_data_ff.pos_y + rd_data_ff.vel_y;
      u_next.pos_z = rd_data_ff.pos_z + rd_data_ff.vel_z;
      u_next.ticks = rd_data_ff.ticks - LIFE_W'(1);
   end

   always_comb begin
      mem_we    = spawn_acc || (adv && u_keep);
      mem_waddr = spawn_acc ? wslot_ff : u_idx_ff;
      if (spawn_acc) begin
         mem_wdata.pos_x = req_ch.data.pos_x;
         mem_wdata.pos_y = req_ch.data.pos_y;
         mem_wdata.pos_z = req_ch.data.pos_z;
         mem_wdata.vel_x = req_ch.data.vel_x;
         mem_wdata.vel_y = req_ch.data.vel_y;
         mem_wdata.vel_z = req_ch.data.vel_z;
         mem_wdata.paint = req_ch.data.paint;
         mem_wdata.ticks = req_ch.data.lifespan;
      end else begin
         mem_wdata = u_next;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[cnt_ff[IDX_W-1:0]];
      end
   end

   prur_proj u_proj_x (
      .clock  (clock),
      .enable (adv),
      .coord  (u_next.pos_y),
      .dim    (width_cl),
      .result (proj_x)
   );

   prur_proj u_proj_y (
      .clock  (clock),
      .enable (adv),
      .coord  (u_next.pos_z),
      .dim    (height_cl),
      .result (proj_y)
   );

   assign q_draw = t_valid_ff && t_keep_ff && proj_x.on_screen && proj_y.on_screen;

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      busy_in       = busy_ff;
      issue_in      = issue_ff;
      cnt_in        = cnt_ff;
      wslot_in      = wslot_ff;
      alive_in      = alive_ff;
      u_valid_in    = u_valid_ff;
      u_fin_in      = u_fin_ff;
      u_idx_in      = u_idx_ff;
      t_valid_in    = t_valid_ff;
      t_fin_in      = t_fin_ff;
      t_keep_in     = t_keep_ff;
      t_paint_in    = t_paint_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_in        = out_ff;
      push          = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (spawn_acc) begin
         alive_in[wslot_ff] = 1'b1;
         wslot_in = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + IDX_W'(1);
      end

      if (tick_acc) begin
         busy_in  = 1'b1;
         issue_in = 1'b1;
         cnt_in   = '0;
      end

      if (adv) begin
         if (issue_ff) begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == END_CNT) begin
               issue_in = 1'b0;
            end
         end
         u_valid_in = issue_ff;
         u_fin_in   = issue_ff && (cnt_ff == END_CNT);
         u_idx_in   = cnt_ff[IDX_W-1:0];

         if (u_live && !u_keep) begin
            alive_in[u_idx_ff] = 1'b0;
         end
         t_valid_in = u_valid_ff;
         t_fin_in   = u_fin_ff;
         t_keep_in  = u_keep;
         t_paint_in = rd_data_ff.paint;

         // One block is held back so that the final one of a tick can carry last.
         if (t_valid_ff && t_fin_ff) begin
            push          = 1'b1;
            busy_in       = 1'b0;
            hold_valid_in = 1'b0;
            if (hold_valid_ff) begin
               out_in = '{draw: 1'b1, block_x: hold_ff.x, block_y: hold_ff.y,
                          block_paint: hold_ff.paint, last: 1'b1};
            end else begin
               out_in = '{draw: 1'b0, block_x: '0, block_y: '0,
                          block_paint: '0, last: 1'b1};
            end
         end else if (q_draw) begin
            if (hold_valid_ff) begin
               push   = 1'b1;
               out_in = '{draw: 1'b1, block_x: hold_ff.x, block_y: hold_ff.y,
                          block_paint: hold_ff.paint, last: 1'b0};
            end
            hold_in       = '{x: proj_x.coord, y: proj_y.coord, paint: t_paint_ff};
            hold_valid_in = 1'b1;
         end
      end

      out_valid_in = push ? 1'b1 : (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         busy_ff       <= 1'b0;
         issue_ff      <= 1'b0;
         cnt_ff        <= '0;
         wslot_ff      <= '0;
         alive_ff      <= '0;
         u_valid_ff    <= 1'b0;
         t_valid_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         busy_ff       <= busy_in;
         issue_ff      <= issue_in;
         cnt_ff        <= cnt_in;
         wslot_ff      <= wslot_in;
         alive_ff      <= alive_in;
         u_valid_ff    <= u_valid_in;
         t_valid_ff    <= t_valid_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_fin_ff   <= u_fin_in;
      u_idx_ff   <= u_idx_in;
      t_fin_ff   <= t_fin_in;
      t_keep_ff  <= t_keep_in;
      t_paint_ff <= t_paint_in;
      hold_ff    <= hold_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;

   `ASSERT_IMPL(a_hold_in_tick, clock, reset, hold_valid_ff, busy_ff)
   `ASSERT_IMPL(a_mid_result_in_tick, clock, reset,
                rsp_ch.valid && !rsp_ch.data.last, busy_ff)
   `ASSERT_IMPL(a_spawn_no_walk, clock, reset, spawn_acc,
                !u_valid_ff && !t_valid_ff && !issue_ff)
   `ASSERT_IMPL(a_marker_is_last, clock, reset,
                rsp_ch.valid && !rsp_ch.data.draw, rsp_ch.data.last)

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the particle ring update and render block. Spawn
// and tick requests go in over the request channel while a predictor keeps
// its own copy of the slot ring and queues the blocks each tick must draw.
// Every result is checked field by field against that queue under random
// idling on both channels, a long output hold-off and several screen sizes.
// ----------------------------------------------------------------------------
module tb;
   import prur_pkg::*;

   localparam int SLOTS       = SLOTS_DEF;
   localparam int PIXEL_SCALE = 40;
   localparam int WATCHDOG    = 4000;
   localparam int TAIL_CYCLES = SLOTS + 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DIM_W-1:0]       csr_wdata;

   prur_req_if req_ch ();
   prur_rsp_if rsp_ch ();

   particle_ring_update_render DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted state of the slot ring and the screen registers.
   logic               live [SLOTS];
   logic [LIFE_W-1:0]  life_left [SLOTS];
   logic [COORD_W-1:0] pos_m [SLOTS][3];
   logic [COORD_W-1:0] vel_m [SLOTS][3];
   logic [PAINT_W-1:0] paint_m [SLOTS];
   int unsigned        ring_ptr;
   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;

   rsp_type expected_blocks [$];

   int  mismatches;
   int  requests_sent;
   int  spawns_sent;
   int  ticks_sent;
   int  results_checked;
   int  screens_used;
   int  most_blocks;
   int  quiet_cycles;
   int  rsp_holdoff;
   bit  no_idle;
   rsp_type want;
   rsp_type got;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned used_dim(input logic [DIM_W-1:0] d);
      if (d < DIM_MIN) return 32'(DIM_MIN);
      if (d > DIM_MAX) return 32'(DIM_MAX);
      return 32'(d);
   endfunction

   function automatic longint screen_coord(input logic [COORD_W-1:0] c,
                                           input int unsigned dim);
      longint t;
      t = longint'($signed(c)) * PIXEL_SCALE + longint'(dim / 2) * (1 << FRAC_W);
      return t / (1 << FRAC_W);
   endfunction

   // World coordinate whose projection lands at or just past pixel pix;
   // rounding up keeps non-negative pixels exact.
   function automatic logic [COORD_W-1:0] place_coord(input int pix,
                                                       input int unsigned dim);
      longint n;
      n = longint'(pix - int'(dim / 2)) * (1 << FRAC_W);
      if (n >= 0) return COORD_W'((n + PIXEL_SCALE - 1) / PIXEL_SCALE);
      return COORD_W'(n / PIXEL_SCALE);
   endfunction

   function automatic req_type spawn_at(input int px, input int py,
                                        input logic [LIFE_W-1:0] life,
                                        input logic [PAINT_W-1:0] color);
      req_type it;
      it.cmd      = CMD_SPAWN;
      it.pos_x    = $urandom;
      it.pos_y    = place_coord(px, used_dim(width_reg));
      it.pos_z    = place_coord(py, used_dim(height_reg));
      it.vel_x    = $urandom;
      it.vel_y    = '0;
      it.vel_z    = '0;
      it.paint    = color;
      it.lifespan = life;
      return it;
   endfunction

   function automatic req_type rand_tick();
      req_type it;
      it.cmd      = CMD_TICK;
      it.pos_x    = $urandom;
      it.pos_y    = $urandom;
      it.pos_z    = $urandom;
      it.vel_x    = $urandom;
      it.vel_y    = $urandom;
      it.vel_z    = $urandom;
      it.paint    = $urandom;
      it.lifespan = LIFE_W'($urandom);
      return it;
   endfunction

   // Mostly particles near the screen with slow drift, some fully random.
   function automatic req_type rand_spawn();
      req_type     it;
      int unsigned w;
      int unsigned h;
      int          r;
      w  = used_dim(width_reg);
      h  = used_dim(height_reg);
      it = rand_tick();
      it.cmd = CMD_SPAWN;
      if ($urandom_range(0, 9) >= 2) begin
         it.pos_y = place_coord(int'($urandom_range(0, w + 3)) - 2, w);
         it.pos_z = place_coord(int'($urandom_range(0, h + 3)) - 2, h);
         it.vel_y = int'($urandom_range(0, 6 * 1638)) - 3 * 1638;
         it.vel_z = int'($urandom_range(0, 6 * 1638)) - 3 * 1638;
      end
      r = $urandom_range(0, 19);
      if (r < 2)
         it.lifespan = LIFE_W'(r);
      else if (r == 2)
         it.lifespan = LIFE_W'($urandom);
      else
         it.lifespan = LIFE_W'($urandom_range(2, 12));
      return it;
   endfunction

   // Applies one accepted request to the predicted ring and queues the
   // blocks a tick draws, or the empty marker.
   task automatic advance_ring(input req_type it);
      int unsigned w;
      int unsigned h;
      longint      sx;
      longint      sy;
      rsp_type     blk;
      rsp_type     tick_blocks [$];
      if (it.cmd == CMD_SPAWN) begin
         pos_m[ring_ptr][0]  = it.pos_x;
         pos_m[ring_ptr][1]  = it.pos_y;
         pos_m[ring_ptr][2]  = it.pos_z;
         vel_m[ring_ptr][0]  = it.vel_x;
         vel_m[ring_ptr][1]  = it.vel_y;
         vel_m[ring_ptr][2]  = it.vel_z;
         paint_m[ring_ptr]   = it.paint;
         life_left[ring_ptr] = it.lifespan;
         live[ring_ptr]      = 1'b1;
         ring_ptr            = (ring_ptr + 1) % SLOTS;
         spawns_sent++;
      end else begin
         w = used_dim(width_reg);
         h = used_dim(height_reg);
         for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
               if (life_left[i] <= 1) begin
                  live[i]      = 1'b0;
                  life_left[i] = '0;
               end else begin
                  life_left[i] = life_left[i] - 1'b1;
                  for (int k = 0; k < 3; k++)
                     pos_m[i][k] = pos_m[i][k] + vel_m[i][k];
                  sx = screen_coord(pos_m[i][1], w);
                  sy = screen_coord(pos_m[i][2], h);
                  if (sx >= 0 && sx < longint'(w) - 1 && sy >= 0 && sy < longint'(h) - 1) begin
                     blk.draw        = 1'b1;
                     blk.block_x     = sx[SCR_W-1:0];
                     blk.block_y     = sy[SCR_W-1:0];
                     blk.block_paint = paint_m[i];
                     blk.last        = 1'b0;
                     tick_blocks.push_back(blk);
                  end
               end
            end
         end
         if (tick_blocks.size() == 0) begin
            blk = '0;
            blk.last = 1'b1;
            tick_blocks.push_back(blk);
         end else begin
            tick_blocks[tick_blocks.size() - 1].last = 1'b1;
         end
         if (tick_blocks.size() > most_blocks) most_blocks = tick_blocks.size();
         foreach (tick_blocks[j]) expected_blocks.push_back(tick_blocks[j]);
         ticks_sent++;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at result %0d: %s", results_checked, msg);
      mismatches++;
   endtask

   // Offers one request and returns at the edge that accepts it. Valid stays
   // high unless an idle gap follows, so back-to-back requests never lower it.
   task automatic send_request(input req_type it);
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_ring(it);
      requests_sent++;
      while (!no_idle && $urandom_range(0, 99) < 31) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stops offering requests and waits until every predicted block is out,
   // then lets a trailing spawn finish.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic set_screen(input int unsigned w, input int unsigned h);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= w[DIM_W-1:0];
      @(posedge clock);
      width_reg = w[DIM_W-1:0];
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= h[DIM_W-1:0];
      @(posedge clock);
      height_reg = h[DIM_W-1:0];
      // A write to an unused index must leave both sizes alone.
      csr_index <= $urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3;
      csr_wdata <= DIM_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      screens_used++;
   endtask

   task automatic test_empty_tick();
      send_request(rand_tick());
   endtask

   task automatic test_placement();
      send_request(spawn_at(160, 100, 3, 32'h00ff_00ff));
      send_request(spawn_at(318, 198, 3, 32'h1234_5678));
      send_request(spawn_at(319, 100, 3, 32'hdead_beef));
      send_request(spawn_at(0, 0, 3, 32'h0000_0001));
      send_request(spawn_at(-2, 50, 3, 32'h8000_0000));
      // Slightly left of pixel zero still truncates onto the screen.
      send_request(spawn_at(-1, 60, 3, 32'h5555_aaaa));
      send_request(rand_tick());
   endtask

   task automatic test_lifespans();
      send_request(spawn_at(10, 10, 0, 32'h1111_1111));
      send_request(spawn_at(12, 12, 1, 32'h2222_2222));
      send_request(spawn_at(14, 14, 2, 32'h3333_3333));
      send_request(spawn_at(16, 16, 16'hffff, 32'h4444_4444));
      send_request(rand_tick());
      send_request(rand_tick());
   endtask

   task automatic test_position_wrap();
      req_type it;
      it = spawn_at(100, 100, 5, 32'hffff_ffff);
      it.pos_x = 32'sh7fff_ffff;
      it.vel_x = 32'sh7fff_ffff;
      it.pos_y = 32'sh7fff_ffff;
      it.vel_y = 32'sh0000_0001;
      send_request(it);
      // Most negative plus most negative wraps to zero, the screen center.
      it = spawn_at(100, 100, 5, 32'h0000_0000);
      it.pos_y = 32'sh8000_0000;
      it.vel_y = 32'sh8000_0000;
      it.pos_z = 32'sh8000_0000;
      it.vel_z = 32'sh8000_0000;
      send_request(it);
      send_request(rand_tick());
   endtask

   task automatic test_screen_extremes();
      set_screen(DIM_MIN, DIM_MIN);
      send_request(spawn_at(0, 0, 3, 32'hcafe_f00d));
      send_request(rand_tick());
      set_screen(DIM_MAX, DIM_MAX);
      send_request(spawn_at(4094, 4094, 3, 32'h0bad_cafe));
      send_request(spawn_at(4095, 0, 3, 32'hface_b00c));
      send_request(rand_tick());
      set_screen(WIDTH_RESET, HEIGHT_RESET);
   endtask

   // Output held off while ticks keep coming, so the walk freezes and the
   // request channel backs up.
   task automatic test_backpressure();
      req_type it;
      repeat (8) begin
         it = rand_spawn();
         it.pos_y = place_coord($urandom_range(0, 317), used_dim(width_reg));
         it.pos_z = place_coord($urandom_range(0, 197), used_dim(height_reg));
         it.lifespan = LIFE_W'(30);
         send_request(it);
      end
      rsp_holdoff = 400;
      repeat (3) send_request(rand_tick());
      send_request(rand_spawn());
      send_request(rand_tick());
      settle();
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_screen(WIDTH_RESET, HEIGHT_RESET);
            1: set_screen(DIM_MIN, DIM_MIN);
            2: set_screen(DIM_MAX, DIM_MAX);
            3: set_screen(0, 1);
            4: set_screen(8191, 4097);
            default: set_screen($urandom_range(2, 700), $urandom_range(2, 700));
         endcase
         no_idle = (p == 2);
         repeat (26) begin
            if ($urandom_range(0, 99) < 25)
               send_request(rand_tick());
            else
               send_request(rand_spawn());
         end
      end
      no_idle = 1'b0;
   endtask

   // Result receiver: random idling, or a counted hold-off when requested.
   initial begin : rsp_ready_driver
      int n;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (rsp_holdoff > 0) begin
            n = rsp_holdoff;
            rsp_holdoff = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 31);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("unexpected result draw=%0b x=%0d y=%0d",
                                      got.draw, got.block_x, got.block_y));
         end else begin
            want = expected_blocks.pop_front();
            if (got.draw !== want.draw)
               report_mismatch($sformatf("draw %0b, expected %0b", got.draw, want.draw));
            if (got.block_x !== want.block_x)
               report_mismatch($sformatf("block_x %0d, expected %0d",
                                         got.block_x, want.block_x));
            if (got.block_y !== want.block_y)
               report_mismatch($sformatf("block_y %0d, expected %0d",
                                         got.block_y, want.block_y));
            if (got.block_paint !== want.block_paint)
               report_mismatch($sformatf("block_paint %h, expected %h",
                                         got.block_paint, want.block_paint));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
         $display("tb: no handshake for %0d cycles, %0d results still expected",
                  WATCHDOG, expected_blocks.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= CSR_SCREEN_WIDTH;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
         live[i]      = 1'b0;
         life_left[i] = '0;
      end
      ring_ptr        = 0;
      width_reg       = WIDTH_RESET;
      height_reg      = HEIGHT_RESET;
      mismatches      = 0;
      requests_sent   = 0;
      spawns_sent     = 0;
      ticks_sent      = 0;
      results_checked = 0;
      screens_used    = 1;
      most_blocks     = 0;
      quiet_cycles    = 0;
      rsp_holdoff     = 0;
      no_idle         = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_tick();
      test_placement();
      test_lifespans();
      test_position_wrap();
      test_screen_extremes();
      test_backpressure();
      test_random_phases();
      settle();

      $display("tb: %0d requests (%0d spawns, %0d ticks), %0d results checked",
               requests_sent, spawns_sent, ticks_sent, results_checked);
      $display("tb: %0d screen size settings, up to %0d blocks in one tick",
               screens_used, most_blocks);
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
